FILE: design/pnea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnea_pkg
// shared types and constants for the partial noise energy adder
// ----------------------------------------------------------------------------
package pnea_pkg;

    // control that travels alongside each beat in the step pipeline
    typedef struct packed {
        logic valid;
        logic pos;   // new noise energy above zero
        logic sat;   // root operand at or above 2^32
    } ctl_t;

    localparam int AMP_W   = 16;
    localparam int BW_W    = 16;
    localparam int NOISE_W = 33;
    localparam int ROOT_W  = 16;
    localparam int ROOT_IN_W = 2 * ROOT_W;

endpackage

FILE: design/pnea_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnea_if
// valid/ready channels for partial points and their results
// ----------------------------------------------------------------------------
interface pnea_in_if;
    logic                                valid;
    logic                                ready;
    logic [pnea_pkg::AMP_W-1:0]          amplitude_in;
    logic [pnea_pkg::BW_W-1:0]           bandwidth_in;
    logic signed [pnea_pkg::NOISE_W-1:0] noise_energy;

    modport source (output valid, amplitude_in, bandwidth_in, noise_energy, input ready);
    modport sink (input valid, amplitude_in, bandwidth_in, noise_energy, output ready);
endinterface

interface pnea_out_if;
    logic                        valid;
    logic                        ready;
    logic [pnea_pkg::AMP_W-1:0]  amplitude_out;
    logic [pnea_pkg::BW_W-1:0]   bandwidth_out;
    logic                        saturated;

    modport source (output valid, amplitude_out, bandwidth_out, saturated, input ready);
    modport sink (input valid, amplitude_out, bandwidth_out, saturated, output ready);
endinterface

FILE: design/partial_noise_energy_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partial_noise_energy_adder
// adds signed noise energy to a partial point, returns new amplitude/bandwidth
// ----------------------------------------------------------------------------
// path: the stage 1 and stage 2 registers, then the bit-per-stage divider and root
// steps, then the output register, from input beat to result beat
// throughput: one beat per cycle; the whole pipeline holds while the result
// beat waits, so input ready follows the output side
// reset: rst_n clears all valid bits at once; data registers are not reset
// ----------------------------------------------------------------------------
module partial_noise_energy_adder #(
    parameter int FRAC_BITS = 15
) (
    input  logic clk,
    input  logic rst_n,
    pnea_in_if.sink    point,
    pnea_out_if.source result
);

    // n = e*bw >> F fits in 48-F bits; energies are kept at least 32 bits
    localparam int NW = 48 - FRAC_BITS;
    localparam int EW = (NW > 32) ? NW : 32;
    localparam int SW = EW + 2;          // signed sums
    localparam int TW = EW + 1;          // divider operands
    localparam int QW = FRAC_BITS + 1;   // quotient, up to 2^F
    localparam int L  = (QW > pnea_pkg::ROOT_W) ? QW : pnea_pkg::ROOT_W;
    localparam int RW = pnea_pkg::ROOT_IN_W;

    // global advance: move when the result slot is free or being taken
    logic en;
    logic out_valid_reg;
    assign en          = !out_valid_reg || result.ready;
    assign point.ready = en;

    // stage 1: amplitude squared
    logic                     v1_reg;
    logic [31:0]              e1_reg;
    logic [15:0]              bw1_reg;
    logic signed [32:0]       add1_reg;

    // stage 2: noise energy from bandwidth
    logic                     v2_reg;
    logic [31:0]              e2_reg;
    logic [NW-1:0]            n2_reg;
    logic signed [32:0]       add2_reg;
    logic [47:0]              prod2;

    // stage 3 comb: raise total, form sums and operands
    logic [EW-1:0]            emax;
    logic signed [SW-1:0]     s3, tot3, diff3, v3;
    pnea_pkg::ctl_t           ctl3;

    assign prod2 = 48'(e1_reg) * 48'(bw1_reg);

    always_comb
    begin
        emax  = (EW'(e2_reg) < EW'(n2_reg)) ? EW'(n2_reg) : EW'(e2_reg);
        s3    = SW'($signed({1'b0, n2_reg})) + SW'(add2_reg);
        tot3  = $signed({2'b00, emax}) + SW'(add2_reg);
        diff3 = $signed({2'b00, emax}) - SW'($signed({1'b0, n2_reg}));
        ctl3.valid = v2_reg;
        ctl3.pos   = (s3 > 0);
        v3         = ctl3.pos ? tot3 : diff3;
        // root operand at or above 2^32 gives a root above 65535
        ctl3.sat   = (v3 >>> RW) != 0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= point.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg   <= 32'(point.amplitude_in) * 32'(point.amplitude_in);
            bw1_reg  <= point.bandwidth_in;
            add1_reg <= point.noise_energy;
            e2_reg   <= e1_reg;
            n2_reg   <= prod2[47:FRAC_BITS];
            add2_reg <= add1_reg;
        end
    end

    // step pipeline: divider s*2^F/total and root of v, one bit per stage
    pnea_pkg::ctl_t  ctl_p [L+1];
    logic [TW-1:0]   rem_p [L+1];
    logic [TW-1:0]   tot_p [L+1];
    logic [QW-1:0]   quo_p [L+1];
    logic [RW-1:0]   sv_p  [L+1];
    logic [RW-1:0]   sr_p  [L+1];

    // the first pipeline stage sits on the stage 3 logic
    assign ctl_p[0] = ctl3;
    assign rem_p[0] = TW'(s3);
    assign tot_p[0] = TW'(tot3);
    assign quo_p[0] = '0;
    assign sv_p[0]  = RW'(v3);
    assign sr_p[0]  = '0;

    genvar k;
    generate
        for (k = 0; k < L; k++)
        begin : g_step
            pnea_step #(
                .TW      (TW),
                .QW      (QW),
                .K       (k),
                .DIV_ON  ((k < QW) ? 1 : 0),
                .SQRT_ON ((k < pnea_pkg::ROOT_W) ? 1 : 0)
            ) u_step (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .ctl_in  (ctl_p[k]),
                .rem_in  (rem_p[k]),
                .tot_in  (tot_p[k]),
                .quo_in  (quo_p[k]),
                .sv_in   (sv_p[k]),
                .sr_in   (sr_p[k]),
                .ctl_out (ctl_p[k+1]),
                .rem_out (rem_p[k+1]),
                .tot_out (tot_p[k+1]),
                .quo_out (quo_p[k+1]),
                .sv_out  (sv_p[k+1]),
                .sr_out  (sr_p[k+1])
            );
        end
    endgenerate

    // output register: clamp and select
    logic [15:0] amp_reg, amp_next, bw_reg, bw_next;
    logic        sat_reg;
    pnea_pkg::ctl_t ctl_l;
    logic [QW-1:0]  q_l;

    always_comb
    begin
        ctl_l    = ctl_p[L];
        q_l      = quo_p[L];
        amp_next = ctl_l.sat ? 16'hFFFF : 16'(sr_p[L]);
        bw_next  = 16'd0;
        if (ctl_l.pos)
        begin
            // wide formats can reach 2^F above 16 bits
            bw_next = (33'(q_l) > 33'h0FFFF) ? 16'hFFFF : 16'(q_l);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl_l.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            amp_reg <= amp_next;
            bw_reg  <= bw_next;
            sat_reg <= ctl_l.sat;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.amplitude_out = amp_reg;
    assign result.bandwidth_out = bw_reg;
    assign result.saturated     = sat_reg;

endmodule

FILE: design/pnea_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnea_step
// one registered step of the restoring divider and the integer square root
// ----------------------------------------------------------------------------
module pnea_step #(
    parameter int TW = 34,
    parameter int QW = 16,
    parameter int K  = 0,
    parameter int DIV_ON  = 1,
    parameter int SQRT_ON = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  pnea_pkg::ctl_t                    ctl_in,
    input  logic [TW-1:0]                     rem_in,
    input  logic [TW-1:0]                     tot_in,
    input  logic [QW-1:0]                     quo_in,
    input  logic [pnea_pkg::ROOT_IN_W-1:0]    sv_in,
    input  logic [pnea_pkg::ROOT_IN_W-1:0]    sr_in,
    output pnea_pkg::ctl_t                    ctl_out,
    output logic [TW-1:0]                     rem_out,
    output logic [TW-1:0]                     tot_out,
    output logic [QW-1:0]                     quo_out,
    output logic [pnea_pkg::ROOT_IN_W-1:0]    sv_out,
    output logic [pnea_pkg::ROOT_IN_W-1:0]    sr_out
);

    localparam int RW = pnea_pkg::ROOT_IN_W;
    localparam int SH = (SQRT_ON != 0) ? (RW - 2 - 2 * K) : 0;
    localparam logic [RW-1:0] BITC = RW'(1) << SH;

    pnea_pkg::ctl_t  ctl_reg;
    logic [TW-1:0]   rem_reg, rem_next, tot_reg;
    logic [QW-1:0]   quo_reg, quo_next;
    logic [RW-1:0]   sv_reg, sv_next, sr_reg, sr_next;

    logic [TW:0]     rem_sh, tot_x;
    logic            ge;
    logic [RW-1:0]   trial;

    always_comb
    begin
        rem_sh   = (K == 0) ? {1'b0, rem_in} : {rem_in, 1'b0};
        tot_x    = {1'b0, tot_in};
        ge       = (rem_sh >= tot_x);
        rem_next = rem_in;
        quo_next = quo_in;
        if (DIV_ON != 0)
        begin
            rem_next = ge ? TW'(rem_sh - tot_x) : TW'(rem_sh);
            quo_next = {quo_in[QW-2:0], ge};
        end

        trial   = sr_in + BITC;
        sv_next = sv_in;
        sr_next = sr_in;
        if (SQRT_ON != 0)
        begin
            if (sv_in >= trial)
            begin
                sv_next = sv_in - trial;
                sr_next = (sr_in >> 1) + BITC;
            end
            else
            begin
                sr_next = sr_in >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            tot_reg <= tot_in;
            quo_reg <= quo_next;
            sv_reg  <= sv_next;
            sr_reg  <= sr_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign tot_out = tot_reg;
    assign quo_out = quo_reg;
    assign sv_out  = sv_reg;
    assign sr_out  = sr_reg;

endmodule
